@@ rtl/dgcc_pkg.sv @@
package dgcc_pkg;

    // Port-level widths
    localparam int PORT_W     = 32;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REF_ONE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TWO       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_THREE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINTS_VALID  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MANUAL_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ENABLE = 3'd5;

    // Taught-point patterns that select a correction
    localparam logic [2:0] PV_NONE    = 3'b000;
    localparam logic [2:0] PV_ONE     = 3'b001;
    localparam logic [2:0] PV_ONE_TWO = 3'b011;
    localparam logic [2:0] PV_ALL     = 3'b111;

endpackage

@@ rtl/dgcc_div.sv @@
module dgcc_div #(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COORD_WIDTH:0]   num,
    input  logic [COORD_WIDTH:0]   den,
    output logic                   done,
    output logic [INDEX_WIDTH-1:0] idx
);

    localparam int CW    = COORD_WIDTH;
    localparam int IW    = INDEX_WIDTH;
    localparam int RW    = CW + 2;
    localparam int DW    = CW + 2 + IW;
    localparam int CNT_W = $clog2(IW);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(IW - 1);

    localparam logic [IW-1:0] IDX_MIN = {1'b1, {(IW-1){1'b0}}};
    localparam logic [IW-1:0] IDX_MAX = {1'b0, {(IW-1){1'b1}}};

    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_PREP = 3'd1;
    localparam logic [2:0] P_OVF  = 3'd2;
    localparam logic [2:0] P_STEP = 3'd3;
    localparam logic [2:0] P_FIN  = 3'd4;

    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [CW:0]      an_reg;
    logic [CW:0]      ad_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic [RW-1:0]    rem_reg;
    logic [DW-1:0]    dsh_reg;
    logic [IW-1:0]    quo_reg;
    logic             ovf_reg;
    logic [IW-1:0]    idx_reg;

    logic             ge;
    logic [IW-1:0]    idx_next;

    // Compare remainder against the shifted divisor
    assign ge = ({{IW{1'b0}}, rem_reg} >= dsh_reg);

    // Saturate the rounded magnitude and apply the sign
    always_comb
    begin
        if (zero_reg)
        begin
            idx_next = '0;
        end
        else if (neg_reg)
        begin
            if (ovf_reg || (quo_reg[IW-1] && (|quo_reg[IW-2:0])))
                idx_next = IDX_MIN;
            else
                idx_next = ~quo_reg + 1'b1;
        end
        else
        begin
            if (ovf_reg || quo_reg[IW-1])
                idx_next = IDX_MAX;
            else
                idx_next = quo_reg;
        end
    end

    // Sequence the division
    always_comb
    begin
        case (phase_reg)
            P_IDLE:  phase_next = start ? P_PREP : P_IDLE;
            P_PREP:  phase_next = P_OVF;
            P_OVF:   phase_next = P_STEP;
            P_STEP:  phase_next = (cnt_reg == '0) ? P_FIN : P_STEP;
            P_FIN:   phase_next = P_IDLE;
            default: phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == P_FIN);
            if (phase_reg == P_OVF)
                cnt_reg <= LAST;
            else if (phase_reg == P_STEP)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Datapath: magnitudes, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    an_reg   <= num[CW] ? (~num + 1'b1) : num;
                    ad_reg   <= den[CW] ? (~den + 1'b1) : den;
                    neg_reg  <= num[CW] ^ den[CW];
                    zero_reg <= (den == '0);
                end
            end
            P_PREP:
            begin
                // 2|n| + |d| over 2|d|, divisor aligned above the quotient range
                rem_reg <= {an_reg, 1'b0} + RW'(ad_reg);
                dsh_reg <= {ad_reg, 1'b0, {IW{1'b0}}};
            end
            P_OVF:
            begin
                ovf_reg <= ge;
                quo_reg <= '0;
                dsh_reg <= dsh_reg >> 1;
            end
            P_STEP:
            begin
                if (ge)
                    rem_reg <= rem_reg - dsh_reg[RW-1:0];
                quo_reg <= {quo_reg[IW-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
            end
            P_FIN:
            begin
                idx_reg <= idx_next;
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign idx  = idx_reg;

endmodule

@@ rtl/dgcc_mac.sv @@
module dgcc_mac #(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [COORD_WIDTH-1:0] base,
    input  logic [INDEX_WIDTH-1:0] n1,
    input  logic [INDEX_WIDTH-1:0] n2,
    input  logic [COORD_WIDTH-1:0] m1,
    input  logic [COORD_WIDTH-1:0] m2,
    output logic                   done,
    output logic [COORD_WIDTH-1:0] acc
);

    localparam int CW    = COORD_WIDTH;
    localparam int IW    = INDEX_WIDTH;
    localparam int CNT_W = $clog2(IW);

    localparam logic [CNT_W-1:0] LAST = CNT_W'(IW - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [IW-1:0]    n1_reg;
    logic [IW-1:0]    n2_reg;
    logic [CW-1:0]    m1_reg;
    logic [CW-1:0]    m2_reg;
    logic [CW-1:0]    acc_reg;

    logic [CW-1:0]    sum;
    logic [CW-1:0]    acc_next;

    // Partial products of the current index bit; the top bit weighs negative
    assign sum      = (n1_reg[0] ? m1_reg : '0) + (n2_reg[0] ? m2_reg : '0);
    assign acc_next = (cnt_reg == LAST) ? (acc_reg - sum) : (acc_reg + sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                    busy_reg <= 1'b0;
            end
        end
    end

    // Shift index bits out, multiplicands up, accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n1_reg  <= n1;
            n2_reg  <= n2;
            m1_reg  <= m1;
            m2_reg  <= m2;
            acc_reg <= base;
        end
        else if (busy_reg)
        begin
            n1_reg  <= n1_reg >> 1;
            n2_reg  <= n2_reg >> 1;
            m1_reg  <= m1_reg << 1;
            m2_reg  <= m2_reg << 1;
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

@@ rtl/die_grid_coordinate_correct_unit.sv @@
// Channel   Direction  Handshake              Word
// in        input      in_valid / in_ready    intended_x, intended_y
// out       output     out_valid / out_ready  actual_x, actual_y, corrected
// cfg       input      cfg_write              cfg_index, cfg_data
//
// One word is in flight at a time. Without all three points, a word passes the
// error, mean and add states and its result is registered once the output is free;
// the next word is then taken. With all three points, two lattice-index dividers
// (one quotient bit per cycle) and two shift-add lanes (one index bit per cycle) run
// between the mean and output states. Reset clears control, the taught references
// and the registers. A stalled result is held while the next word is already taken.
module die_grid_coordinate_correct_unit
    import dgcc_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PORT_W-1:0]     intended_x,
    input  logic [PORT_W-1:0]     intended_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PORT_W-1:0]     actual_x,
    output logic [PORT_W-1:0]     actual_y,
    output logic                  corrected,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = INDEX_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ERR  = 3'd1;
    localparam logic [2:0] S_MEAN = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // Configuration
    logic [CFG_DATA_W-1:0] ref_one_reg;
    logic [CFG_DATA_W-1:0] ref_two_reg;
    logic [CFG_DATA_W-1:0] ref_three_reg;
    logic [2:0]            pv_reg;
    logic [CFG_DATA_W-1:0] offset_reg;
    logic                  oe_reg;

    // Control
    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic                  out_valid_reg;
    logic                  out_load;
    logic                  moved;

    // Taught history
    logic signed [CW-1:0]  frx_reg;
    logic signed [CW-1:0]  fry_reg;
    logic signed [CW-1:0]  srx_reg;
    logic signed [CW-1:0]  sry_reg;

    // Working word
    logic signed [CW-1:0]  x_reg;
    logic signed [CW-1:0]  y_reg;
    logic signed [CW:0]    e1x_reg;
    logic signed [CW:0]    e1y_reg;
    logic signed [CW:0]    e2x_reg;
    logic signed [CW:0]    e2y_reg;
    logic signed [CW:0]    numx_reg;
    logic signed [CW:0]    numy_reg;
    logic signed [CW:0]    denx_reg;
    logic signed [CW:0]    deny_reg;
    logic [CW-1:0]         ex_reg;
    logic [CW-1:0]         ey_reg;
    logic [CW-1:0]         ex_next;
    logic [CW-1:0]         ey_next;
    logic signed [CW-1:0]  resx_reg;
    logic signed [CW-1:0]  resy_reg;
    logic                  corr_reg;
    logic [PORT_W-1:0]     actual_x_reg;
    logic [PORT_W-1:0]     actual_y_reg;
    logic                  corrected_reg;

    // Coordinates in working precision
    logic signed [CW-1:0]  in_x;
    logic signed [CW-1:0]  in_y;
    logic signed [CW-1:0]  p1x;
    logic signed [CW-1:0]  p1y;
    logic signed [CW-1:0]  p2x;
    logic signed [CW-1:0]  p2y;
    logic signed [CW-1:0]  p3x;
    logic signed [CW-1:0]  p3y;
    logic signed [CW-1:0]  offx;
    logic signed [CW-1:0]  offy;
    logic signed [CW+1:0]  sumx;
    logic signed [CW+1:0]  sumy;
    logic signed [CW+1:0]  halfx;
    logic signed [CW+1:0]  halfy;
    logic [CW-1:0]         dyx;
    logic [CW-1:0]         dxy;

    // Lattice units
    logic                  div_start;
    logic                  divx_done;
    logic                  divy_done;
    logic [IW-1:0]         nx;
    logic [IW-1:0]         ny;
    logic                  mac_start;
    logic                  macx_done;
    logic                  macy_done;
    logic [CW-1:0]         accx;
    logic [CW-1:0]         accy;

    assign in_x = CW'($signed(intended_x));
    assign in_y = CW'($signed(intended_y));
    assign p1x  = CW'($signed(ref_one_reg[PORT_W +: PORT_W]));
    assign p1y  = CW'($signed(ref_one_reg[0 +: PORT_W]));
    assign p2x  = CW'($signed(ref_two_reg[PORT_W +: PORT_W]));
    assign p2y  = CW'($signed(ref_two_reg[0 +: PORT_W]));
    assign p3x  = CW'($signed(ref_three_reg[PORT_W +: PORT_W]));
    assign p3y  = CW'($signed(ref_three_reg[0 +: PORT_W]));
    assign offx = CW'($signed(offset_reg[PORT_W +: PORT_W]));
    assign offy = CW'($signed(offset_reg[0 +: PORT_W]));

    assign dyx = p2x - p1x;
    assign dxy = p3y - p1y;

    assign moved = (pv_reg == PV_ONE) || (pv_reg == PV_ONE_TWO) || (pv_reg == PV_ALL);

    // Mean of both errors, floored
    assign sumx  = (CW+2)'(e1x_reg) + (CW+2)'(e2x_reg);
    assign sumy  = (CW+2)'(e1y_reg) + (CW+2)'(e2y_reg);
    assign halfx = sumx >>> 1;
    assign halfy = sumy >>> 1;

    // Pick the displacement for the non-lattice cases
    always_comb
    begin
        case (pv_reg)
            PV_ONE:
            begin
                ex_next = e1x_reg[CW-1:0];
                ey_next = e1y_reg[CW-1:0];
            end
            PV_ONE_TWO:
            begin
                ex_next = halfx[CW-1:0];
                ey_next = halfy[CW-1:0];
            end
            default:
            begin
                ex_next = oe_reg ? offx : '0;
                ey_next = oe_reg ? offy : '0;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    assign div_start = (state_reg == S_MEAN) && (pv_reg == PV_ALL);
    assign mac_start = (state_reg == S_DIV) && divx_done && divy_done;

    // Sequence one word
    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = in_valid ? S_ERR : S_IDLE;
            S_ERR:   state_next = S_MEAN;
            S_MEAN:  state_next = (pv_reg == PV_ALL) ? S_DIV : S_ADD;
            S_ADD:   state_next = S_OUT;
            S_DIV:   state_next = (divx_done && divy_done) ? S_MUL : S_DIV;
            S_MUL:   state_next = (macx_done && macy_done) ? S_OUT : S_MUL;
            S_OUT:   state_next = out_load ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    // Control, configuration and taught history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ref_one_reg   <= '0;
            ref_two_reg   <= '0;
            ref_three_reg <= '0;
            pv_reg        <= '0;
            offset_reg    <= '0;
            oe_reg        <= 1'b0;
            frx_reg       <= '0;
            fry_reg       <= '0;
            srx_reg       <= '0;
            sry_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_REF_ONE:       ref_one_reg   <= cfg_data;
                    REG_REF_TWO:       ref_two_reg   <= cfg_data;
                    REG_REF_THREE:     ref_three_reg <= cfg_data;
                    REG_POINTS_VALID:  pv_reg        <= cfg_data[2:0];
                    REG_MANUAL_OFFSET: offset_reg    <= cfg_data;
                    REG_OFFSET_ENABLE: oe_reg        <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            // Record the first or second reference
            if (state_reg == S_ADD)
            begin
                if (pv_reg == PV_NONE)
                begin
                    frx_reg <= x_reg;
                    fry_reg <= y_reg;
                end
                else if (pv_reg == PV_ONE)
                begin
                    srx_reg <= x_reg;
                    sry_reg <= y_reg;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= in_x;
            y_reg <= in_y;
        end

        if (state_reg == S_ERR)
        begin
            e1x_reg  <= (CW+1)'(p1x) - (CW+1)'(frx_reg);
            e1y_reg  <= (CW+1)'(p1y) - (CW+1)'(fry_reg);
            e2x_reg  <= (CW+1)'(p2x) - (CW+1)'(srx_reg);
            e2y_reg  <= (CW+1)'(p2y) - (CW+1)'(sry_reg);
            numx_reg <= (CW+1)'(x_reg) - (CW+1)'(p1x);
            numy_reg <= (CW+1)'(y_reg) - (CW+1)'(p1y);
            denx_reg <= (CW+1)'(p3x) - (CW+1)'(p1x);
            deny_reg <= (CW+1)'(p2y) - (CW+1)'(p1y);
        end

        if (state_reg == S_MEAN)
        begin
            ex_reg <= ex_next;
            ey_reg <= ey_next;
        end

        if (state_reg == S_ADD)
        begin
            resx_reg <= x_reg + ex_reg;
            resy_reg <= y_reg + ey_reg;
            corr_reg <= moved || oe_reg;
        end
        else if ((state_reg == S_MUL) && macx_done && macy_done)
        begin
            resx_reg <= accx;
            resy_reg <= accy;
            corr_reg <= 1'b1;
        end

        if (out_load)
        begin
            actual_x_reg  <= PORT_W'(resx_reg);
            actual_y_reg  <= PORT_W'(resy_reg);
            corrected_reg <= corr_reg;
        end
    end

    // Lattice indexes, rounded and saturated
    dgcc_div #(
        .COORD_WIDTH (CW),
        .INDEX_WIDTH (IW)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (numx_reg),
        .den   (denx_reg),
        .done  (divx_done),
        .idx   (nx)
    );

    dgcc_div #(
        .COORD_WIDTH (CW),
        .INDEX_WIDTH (IW)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (numy_reg),
        .den   (deny_reg),
        .done  (divy_done),
        .idx   (ny)
    );

    // Lattice node: p1 + nx*pitch_x + ny*skew, per axis
    dgcc_mac #(
        .COORD_WIDTH (CW),
        .INDEX_WIDTH (IW)
    ) u_mac_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .base  (p1x),
        .n1    (nx),
        .n2    (ny),
        .m1    (denx_reg[CW-1:0]),
        .m2    (dyx),
        .done  (macx_done),
        .acc   (accx)
    );

    dgcc_mac #(
        .COORD_WIDTH (CW),
        .INDEX_WIDTH (IW)
    ) u_mac_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mac_start),
        .base  (p1y),
        .n1    (ny),
        .n2    (nx),
        .m1    (deny_reg[CW-1:0]),
        .m2    (dxy),
        .done  (macy_done),
        .acc   (accy)
    );

    assign out_valid = out_valid_reg;
    assign actual_x  = actual_x_reg;
    assign actual_y  = actual_y_reg;
    assign corrected = corrected_reg;

endmodule

@@ rtl/dgcc_checker.sv @@
module dgcc_checker
    import dgcc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [PORT_W-1:0] actual_x,
    input logic [PORT_W-1:0] actual_y,
    input logic              corrected
);

    // A taken word keeps the input side closed on the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still open right after a word was taken");

    // No result can be raised in the cycle after a taken word
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result appeared one cycle after the word was taken");

    // A new result comes only out of a busy block
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised while the block was idle");

    // Hold a stalled result
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(actual_x)
            && $stable(actual_y) && $stable(corrected)))
        else $error("stalled result dropped or changed");

endmodule

bind die_grid_coordinate_correct_unit dgcc_checker u_dgcc_checker (.*);

@@ tb/sv/grid_correct_checker.sv @@
`timescale 1ns / 1ps

module grid_correct_checker
    import dgcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [PORT_W-1:0]     intended_x,
    input  logic [PORT_W-1:0]     intended_y,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [PORT_W-1:0]     actual_x,
    input  logic [PORT_W-1:0]     actual_y,
    input  logic                  corrected,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending_words
);

    localparam int     IDX_W   = 16;
    localparam longint IDX_POS = (64'sd1 <<< (IDX_W - 1)) - 1;
    localparam longint IDX_NEG = 64'sd1 <<< (IDX_W - 1);

    typedef struct packed {
        logic [PORT_W-1:0] x;
        logic [PORT_W-1:0] y;
        logic              corr;
    } position_word_t;

    // Shadow copies of the register file
    logic [CFG_DATA_W-1:0] point_one;
    logic [CFG_DATA_W-1:0] point_two;
    logic [CFG_DATA_W-1:0] point_three;
    logic [CFG_DATA_W-1:0] offset_xy;
    logic [2:0]            taught;
    logic                  offset_on;

    // Positions recorded by the learning passes
    longint first_mark_x;
    longint first_mark_y;
    longint second_mark_x;
    longint second_mark_y;

    position_word_t predicted_positions[$];
    int             error_total = 0;

    function automatic longint sext(input logic [31:0] v);
        logic signed [31:0] s;
        s = v;
        return longint'(s);
    endfunction

    // Round the exact quotient half away from zero and clamp to the index range
    function automatic longint lattice_index(input longint num, input longint den);
        longint an;
        longint ad;
        longint q;
        logic   neg;
        if (den == 0)
            return 0;
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = (2 * an + ad) / (2 * ad);
        neg = (num < 0) != (den < 0);
        if (neg) begin
            if (q > IDX_NEG)
                q = IDX_NEG;
            return -q;
        end
        if (q > IDX_POS)
            q = IDX_POS;
        return q;
    endfunction

    // Work out the corrected position and advance the learned references
    function automatic position_word_t correct_position(input logic [31:0] in_x,
                                                         input logic [31:0] in_y);
        longint         x;
        longint         y;
        longint         p1x;
        longint         p1y;
        longint         p2x;
        longint         p2y;
        longint         p3x;
        longint         p3y;
        longint         nx;
        longint         ny;
        logic           moved;
        position_word_t w;
        x     = sext(in_x);
        y     = sext(in_y);
        p1x   = sext(point_one[63:32]);
        p1y   = sext(point_one[31:0]);
        p2x   = sext(point_two[63:32]);
        p2y   = sext(point_two[31:0]);
        p3x   = sext(point_three[63:32]);
        p3y   = sext(point_three[31:0]);
        moved = 1'b0;
        case (taught)
            PV_NONE: begin
                first_mark_x = x;
                first_mark_y = y;
            end
            PV_ONE: begin
                second_mark_x = x;
                second_mark_y = y;
                x = x + (p1x - first_mark_x);
                y = y + (p1y - first_mark_y);
                moved = 1'b1;
            end
            PV_ONE_TWO: begin
                // mean of both errors, halved toward minus infinity
                x = x + (((p2x - second_mark_x) + (p1x - first_mark_x)) >>> 1);
                y = y + (((p2y - second_mark_y) + (p1y - first_mark_y)) >>> 1);
                moved = 1'b1;
            end
            PV_ALL: begin
                nx = lattice_index(x - p1x, p3x - p1x);
                ny = lattice_index(y - p1y, p2y - p1y);
                x  = p1x + nx * (p3x - p1x) + ny * (p2x - p1x);
                y  = p1y + ny * (p2y - p1y) + nx * (p3y - p1y);
                moved = 1'b1;
            end
            default: ;
        endcase
        if (offset_on && !moved) begin
            x = x + sext(offset_xy[63:32]);
            y = y + sext(offset_xy[31:0]);
        end
        w.x    = x[31:0];
        w.y    = y[31:0];
        w.corr = moved | offset_on;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        error_total++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Track config, predict on each accepted input word, compare each result word
    always @(posedge clk or negedge rst_n) begin : watch
        position_word_t want;
        if (!rst_n) begin
            point_one     = '0;
            point_two     = '0;
            point_three   = '0;
            offset_xy     = '0;
            taught        = PV_NONE;
            offset_on     = 1'b0;
            first_mark_x  = 0;
            first_mark_y  = 0;
            second_mark_x = 0;
            second_mark_y = 0;
            predicted_positions.delete();
            pending_words <= 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_REF_ONE:       point_one   = cfg_data;
                    REG_REF_TWO:       point_two   = cfg_data;
                    REG_REF_THREE:     point_three = cfg_data;
                    REG_POINTS_VALID:  taught      = cfg_data[2:0];
                    REG_MANUAL_OFFSET: offset_xy   = cfg_data;
                    REG_OFFSET_ENABLE: offset_on   = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (predicted_positions.size() == 0) begin
                    report_mismatch($sformatf("word with nothing pending: x=%h y=%h c=%b",
                                              actual_x, actual_y, corrected));
                end
                else begin
                    want = predicted_positions.pop_front();
                    if (actual_x !== want.x)
                        report_mismatch($sformatf("actual_x %h, want %h", actual_x, want.x));
                    if (actual_y !== want.y)
                        report_mismatch($sformatf("actual_y %h, want %h", actual_y, want.y));
                    if (corrected !== want.corr)
                        report_mismatch($sformatf("corrected %b, want %b",
                                                  corrected, want.corr));
                end
            end
            if (in_valid && in_ready)
                predicted_positions.push_back(correct_position(intended_x, intended_y));
            pending_words <= predicted_positions.size();
        end
        mismatches <= error_total;
    end

endmodule

@@ tb/sv/die_grid_coordinate_correct_unit_tb.sv @@
`timescale 1ns / 1ps

module die_grid_coordinate_correct_unit_tb;
    import dgcc_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 48;
    localparam int ITEM_BUDGET  = 1600;

    // Patterns that select no reference branch
    localparam logic [2:0] PV_TWO_ONLY  = 3'b010;
    localparam logic [2:0] PV_ONE_THREE = 3'b101;
    localparam logic [2:0] PV_TWO_THREE = 3'b110;

    // Directed lattice origin
    localparam logic [31:0] GX = 32'h0001_0000;
    localparam logic [31:0] GY = 32'h0002_0000;

    logic                  clk        = 1'b1;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [PORT_W-1:0]     intended_x = '0;
    logic [PORT_W-1:0]     intended_y = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic [PORT_W-1:0]     actual_x;
    logic [PORT_W-1:0]     actual_y;
    logic                  corrected;
    logic                  cfg_write  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    int mismatches;
    int pending_words;
    int idle_cycles   = 0;
    int words_sent    = 0;
    int hold_req      = 0;
    bit quiet         = 1'b0;
    bit pressure_done = 1'b0;

    // Current lattice: origin and pitches
    logic [31:0] p1x;
    logic [31:0] p1y;
    logic [31:0] dx;
    logic [31:0] dxy;
    logic [31:0] dy;
    logic [31:0] dyx;

    die_grid_coordinate_correct_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .intended_x (intended_x),
        .intended_y (intended_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .actual_x   (actual_x),
        .actual_y   (actual_y),
        .corrected  (corrected),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    grid_correct_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .intended_x    (intended_x),
        .intended_y    (intended_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .actual_x      (actual_x),
        .actual_y      (actual_y),
        .corrected     (corrected),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending_words (pending_words)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // End the run when no word moves for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Signed value spread over the given number of bits
    function automatic logic [31:0] jitter(input int bits);
        logic [31:0] r;
        r = $urandom();
        return (r >> (32 - bits)) - (32'd1 << (bits - 1));
    endfunction

    function automatic logic [63:0] rand64();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom();
        lo = $urandom();
        return {hi, lo};
    endfunction

    // Receiver: random stalls, long hold-off on request
    initial begin : receiver
        int stall_left;
        int hold_seen;
        bit took;
        stall_left = 0;
        hold_seen  = 0;
        forever begin
            @(posedge clk);
            took = out_valid && out_ready;
            @(negedge clk);
            if (hold_req != hold_seen) begin
                hold_seen  = hold_req;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && (took || $urandom_range(0, 7) == 0)) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offer one input word, hold it until taken
    task automatic send_word(input logic [31:0] x, input logic [31:0] y);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        intended_x <= x;
        intended_y <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Drop valid and wait for every pending result word
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_words == 0);
    endtask

    // One setting of the taught points with a run of random words
    task automatic send_points(input logic [2:0] pv, input int n);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] kx;
        logic [31:0] ky;
        drain();
        quiet = ($urandom_range(0, 4) == 0);
        set_reg(REG_POINTS_VALID, 64'(pv));
        if ((!pressure_done && pv == PV_ALL) || $urandom_range(0, 19) == 0) begin
            hold_req++;
            pressure_done = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                x = $urandom();
                y = $urandom();
            end
            else if (pv == PV_ALL) begin
                kx = $urandom_range(0, 400) - 200;
                ky = $urandom_range(0, 400) - 200;
                x  = p1x + kx * dx + ky * dyx + jitter($urandom_range(2, 22));
                y  = p1y + ky * dy + kx * dxy + jitter($urandom_range(2, 22));
            end
            else begin
                x = p1x + jitter(18);
                y = p1y + jitter(18);
            end
            send_word(x, y);
        end
    endtask

    // Teach sequence: record, shift, average, then snap to the lattice
    task automatic teach_cycle();
        logic [31:0] ox;
        logic [31:0] oy;
        p1x = ($urandom_range(0, 3) == 0) ? $urandom() : jitter(24);
        p1y = ($urandom_range(0, 3) == 0) ? $urandom() : jitter(24);
        if ($urandom_range(0, 9) == 0) begin
            dx  = $urandom();
            dy  = $urandom();
            dxy = $urandom();
            dyx = $urandom();
        end
        else begin
            dx  = jitter(21);
            dy  = jitter(21);
            dxy = jitter(13);
            dyx = jitter(13);
            if ($urandom_range(0, 9) == 0)
                dx = '0;
            if ($urandom_range(0, 9) == 0)
                dy = '0;
        end
        ox = jitter(20);
        oy = jitter(20);
        drain();
        set_reg(REG_REF_ONE, {p1x, p1y});
        set_reg(REG_REF_TWO, {p1x + dyx, p1y + dy});
        set_reg(REG_REF_THREE, {p1x + dx, p1y + dxy});
        set_reg(REG_MANUAL_OFFSET, {ox, oy});
        set_reg(REG_OFFSET_ENABLE, 64'($urandom_range(0, 2) == 0));
        // skip a step now and then to break the sequence
        if ($urandom_range(0, 7) != 0)
            send_points(PV_NONE, $urandom_range(3, 30));
        if ($urandom_range(0, 7) != 0)
            send_points(PV_ONE, $urandom_range(3, 30));
        if ($urandom_range(0, 7) != 0)
            send_points(PV_ONE_TWO, $urandom_range(3, 30));
        if ($urandom_range(0, 7) != 0)
            send_points(PV_ALL, $urandom_range(3, 30));
    endtask

    // Full-range registers and any point pattern
    task automatic noise_phase();
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] r3;
        r1  = rand64();
        r2  = rand64();
        r3  = rand64();
        p1x = r1[63:32];
        p1y = r1[31:0];
        dyx = r2[63:32] - p1x;
        dy  = r2[31:0] - p1y;
        dx  = r3[63:32] - p1x;
        dxy = r3[31:0] - p1y;
        drain();
        set_reg(REG_REF_ONE, r1);
        set_reg(REG_REF_TWO, r2);
        set_reg(REG_REF_THREE, r3);
        set_reg(REG_MANUAL_OFFSET, rand64());
        set_reg(REG_OFFSET_ENABLE, 64'($urandom_range(0, 1)));
        send_points(3'($urandom_range(0, 7)), $urandom_range(3, 20));
    endtask

    task automatic directed();
        set_reg(REG_REF_ONE, {GX, GY});
        set_reg(REG_REF_TWO, {GX + 32'h0000_0800, GY + 32'h000A_0000});
        set_reg(REG_REF_THREE, {GX + 32'h0008_0000, GY + 32'h0000_0400});
        set_reg(REG_POINTS_VALID, 64'(PV_NONE));
        set_reg(REG_MANUAL_OFFSET, 64'h7FFF_FFFF_8000_0000);
        set_reg(REG_OFFSET_ENABLE, 64'd0);
        // record the first reference at the corners of the range
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'h0000_0001);
        // shift by point one's error, with wrap
        drain();
        set_reg(REG_POINTS_VALID, 64'(PV_ONE));
        send_word(GX + 32'h123, GY - 32'h77);
        send_word(32'h8000_0000, 32'h7FFF_FFFF);
        // mean of both errors
        drain();
        set_reg(REG_POINTS_VALID, 64'(PV_ONE_TWO));
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'h7FFF_FFFF, 32'h8000_0001);
        // lattice: exact halves both ways, far corner
        drain();
        set_reg(REG_POINTS_VALID, 64'(PV_ALL));
        send_word(GX + 32'h0004_0000, GY);
        send_word(GX - 32'h0004_0000, GY - 32'h0005_0000);
        send_word(32'h7FFF_FFFF, 32'h8000_0000);
        // unit pitch: indices saturate both ways
        drain();
        set_reg(REG_REF_TWO, {GX, GY - 32'h1});
        set_reg(REG_REF_THREE, {GX + 32'h1, GY});
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(32'h8000_0000, 32'h8000_0000);
        // zero pitch gives index zero
        drain();
        set_reg(REG_REF_TWO, {GX, GY});
        set_reg(REG_REF_THREE, {GX, GY});
        send_word(32'h1234_5678, 32'h9ABC_DEF0);
        // manual offset with no branch taken, with wrap
        drain();
        set_reg(REG_OFFSET_ENABLE, 64'd1);
        set_reg(REG_POINTS_VALID, 64'(PV_TWO_ONLY));
        send_word(32'h7FFF_FFFF, 32'h8000_0000);
        send_word(32'h0000_0001, 32'hFFFF_FFFF);
        // offset while recording the first reference
        drain();
        set_reg(REG_POINTS_VALID, 64'(PV_NONE));
        send_word(32'h0001_0000, 32'h0002_0000);
        // offset flag on a lattice snap adds nothing
        drain();
        set_reg(REG_POINTS_VALID, 64'(PV_ALL));
        send_word(32'h0003_0000, 32'hFFFE_0000);
        drain();
        set_reg(REG_POINTS_VALID, 64'(PV_ONE_THREE));
        send_word(32'hFFFF_0000, 32'h0000_FFFF);
        drain();
        set_reg(REG_OFFSET_ENABLE, 64'd0);
        set_reg(REG_MANUAL_OFFSET, 64'h0);
        set_reg(REG_POINTS_VALID, 64'(PV_TWO_THREE));
        send_word(32'h5555_AAAA, 32'hAAAA_5555);
    endtask

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        directed();
        while (words_sent < ITEM_BUDGET) begin
            if ($urandom_range(0, 3) != 0)
                teach_cycle();
            else
                noise_phase();
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
